@@ hdl/rt2p_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, stage counts and status codes of the two-point rigid transform.
// Depends on nothing; every module of the block imports it.
package rt2p_pkg;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int MAG_W    = COORD_W;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int RAD_W    = SQ_W + 2;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int SQRT_LAT = SQRT_STEPS + 3;

   localparam int QUO_W    = 31;
   localparam int NUM_W    = MAG_W + QUO_W;
   localparam int DEN_W    = ROOT_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_LAT  = DIV_STEPS + 2;

   localparam int UNIT_W   = 32;
   localparam int PROD_W   = 2 * UNIT_W;
   localparam int WIDE_W   = PROD_W + 2;
   localparam int RND_W    = 36;
   localparam int SHIFT_W  = 40;
   localparam int TOL_W    = 16;

   localparam int S_CHK    = SQRT_LAT + 1;
   localparam int S_DIVOUT = S_CHK + DIV_LAT;
   localparam int S_P3     = S_DIVOUT + 3;
   localparam int S_OUT    = S_P3 + 3;
   localparam int PIPE_LAT = S_OUT + 1;
   localparam int COORD_DEPTH = S_OUT - 1;
   localparam int STAT_DEPTH  = S_OUT - 1 - S_CHK;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH   = 2'd1;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd2;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
   localparam logic signed [RND_W-1:0] ONE_Q30 = RND_W'(1073741824);
   localparam logic signed [WIDE_W-1:0] HALF_Q30 = WIDE_W'(536870912);

   typedef struct packed {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
   } coord_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dxo;
      logic signed [DIFF_W-1:0] dyo;
      logic signed [DIFF_W-1:0] dxn;
      logic signed [DIFF_W-1:0] dyn;
   } diff_type;

   // Divides by 2^30 and rounds half away from zero.
   function automatic logic signed [RND_W-1:0] round_q30(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] bias;
      logic signed [WIDE_W-1:0] t;
      bias = v[WIDE_W-1] ? (HALF_Q30 - WIDE_W'(1)) : HALF_Q30;
      t = v + bias;
      return RND_W'(t >>> 30);
   endfunction

endpackage

@@ hdl/rigid_transform_from_two_points.sv @@
`timescale 1ns / 1ps
// Top level of the two-point rigid transform: lengths, unit vectors, rotation, translation.
// Depends on rt2p_pkg, rt2p_sqrt and rt2p_div.
//
// Usage: the request channel carries one segment of a shape before and after a move (eight
// Q15.16 coordinates); the response channel returns one result per request: the rotation
// entries in Q1.30, two 40-bit translations and a status code (ok, length mismatch, or
// degenerate segment; with any status but ok all matrix outputs are zero).
// A transfer happens on a rising edge with valid high and stall low.
// The pipeline depth is set by the 33 root stages of the length units and the 31 quotient
// stages of the four dividers, plus the multiply and rounding stages around them.
// Throughput is one item per cycle while no response waits under stall.
// The whole pipeline moves as one: when a response waits under stall, every stage holds
// and req_stall is raised, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the length tolerance to 1.
// The tolerance register is written through csr_write_enable and csr_write_data; the user
// must do so only while the block holds no item in flight. The block does not enforce it.
module rigid_transform_from_two_points import rt2p_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_old_first_x,
   input  logic signed [COORD_W-1:0] req_old_first_y,
   input  logic signed [COORD_W-1:0] req_old_second_x,
   input  logic signed [COORD_W-1:0] req_old_second_y,
   input  logic signed [COORD_W-1:0] req_new_first_x,
   input  logic signed [COORD_W-1:0] req_new_first_y,
   input  logic signed [COORD_W-1:0] req_new_second_x,
   input  logic signed [COORD_W-1:0] req_new_second_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [UNIT_W-1:0]  rsp_entry_a,
   output logic signed [UNIT_W-1:0]  rsp_entry_b,
   output logic signed [UNIT_W-1:0]  rsp_entry_c,
   output logic signed [UNIT_W-1:0]  rsp_entry_d,
   output logic signed [SHIFT_W-1:0] rsp_shift_x,
   output logic signed [SHIFT_W-1:0] rsp_shift_y,
   output logic [1:0]                rsp_status,
   input  logic                      csr_write_enable,
   input  logic [TOL_W-1:0]          csr_write_data
);

   logic                advance;
   logic                accept;
   logic [PIPE_LAT-1:0] valid_ff;
   logic [PIPE_LAT-1:0] valid_in;
   logic [TOL_W-1:0]    tol_ff;

   diff_type  diff_ff;
   coord_type coord_ff;
   diff_type  dline_ff [SQRT_LAT];
   coord_type cline_ff [COORD_DEPTH];
   logic [1:0] sline_ff [STAT_DEPTH];

   logic [ROOT_W-1:0] n_old;
   logic [ROOT_W-1:0] n_new;
   logic [ROOT_W-1:0] ndiff;
   logic [1:0]        status_in;
   logic [1:0]        status_ff;
   logic [ROOT_W-1:0] n_old_ff;
   logic [ROOT_W-1:0] n_new_ff;
   diff_type          chk_diff_ff;

   logic signed [UNIT_W-1:0] ux1;
   logic signed [UNIT_W-1:0] uy1;
   logic signed [UNIT_W-1:0] ux2;
   logic signed [UNIT_W-1:0] uy2;

   logic signed [PROD_W-1:0] pxx_ff;
   logic signed [PROD_W-1:0] pyy_ff;
   logic signed [PROD_W-1:0] pxy_ff;
   logic signed [PROD_W-1:0] pyx_ff;
   logic signed [WIDE_W-1:0] cv_ff;
   logic signed [WIDE_W-1:0] sv_ff;
   logic signed [RND_W-1:0]  cr;
   logic signed [RND_W-1:0]  sr;
   logic signed [UNIT_W-1:0] c_in;
   logic signed [UNIT_W-1:0] s_in;
   logic signed [UNIT_W-1:0] c3_ff;
   logic signed [UNIT_W-1:0] s3_ff;
   logic signed [UNIT_W-1:0] c4_ff;
   logic signed [UNIT_W-1:0] s4_ff;
   logic signed [UNIT_W-1:0] c5_ff;
   logic signed [UNIT_W-1:0] s5_ff;
   logic signed [PROD_W-1:0] m1_ff;
   logic signed [PROD_W-1:0] m2_ff;
   logic signed [PROD_W-1:0] m3_ff;
   logic signed [PROD_W-1:0] m4_ff;
   logic signed [WIDE_W-1:0] ve_ff;
   logic signed [WIDE_W-1:0] vf_ff;
   logic                     ok_out;

   logic signed [UNIT_W-1:0]  rsp_entry_a_ff;
   logic signed [UNIT_W-1:0]  rsp_entry_b_ff;
   logic signed [UNIT_W-1:0]  rsp_entry_c_ff;
   logic signed [UNIT_W-1:0]  rsp_entry_d_ff;
   logic signed [SHIFT_W-1:0] rsp_shift_x_ff;
   logic signed [SHIFT_W-1:0] rsp_shift_y_ff;
   logic [1:0]                rsp_status_ff;

   assign advance   = !valid_ff[PIPE_LAT-1] || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[PIPE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         tol_ff   <= TOL_RESET;
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
         end
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
      end
   end

   // Entry stage: segment differences and the coordinates needed later.
   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff.dxo <= DIFF_W'(req_old_second_x) - DIFF_W'(req_old_first_x);
         diff_ff.dyo <= DIFF_W'(req_old_second_y) - DIFF_W'(req_old_first_y);
         diff_ff.dxn <= DIFF_W'(req_new_second_x) - DIFF_W'(req_new_first_x);
         diff_ff.dyn <= DIFF_W'(req_new_second_y) - DIFF_W'(req_new_first_y);
         coord_ff.ox <= req_old_first_x;
         coord_ff.oy <= req_old_first_y;
         coord_ff.nx <= req_new_first_x;
         coord_ff.ny <= req_new_first_y;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dline_ff[0] <= diff_ff;
         for (int k = 1; k < SQRT_LAT; k++) begin
            dline_ff[k] <= dline_ff[k-1];
         end
         cline_ff[0] <= coord_ff;
         for (int k = 1; k < COORD_DEPTH; k++) begin
            cline_ff[k] <= cline_ff[k-1];
         end
         sline_ff[0] <= status_ff;
         for (int k = 1; k < STAT_DEPTH; k++) begin
            sline_ff[k] <= sline_ff[k-1];
         end
      end
   end

   rt2p_sqrt u_len_old (
      .clock   (clock),
      .advance (advance),
      .dx      (diff_ff.dxo),
      .dy      (diff_ff.dyo),
      .root    (n_old)
   );

   rt2p_sqrt u_len_new (
      .clock   (clock),
      .advance (advance),
      .dx      (diff_ff.dxn),
      .dy      (diff_ff.dyn),
      .root    (n_new)
   );

   assign ndiff = (n_old > n_new) ? (n_old - n_new) : (n_new - n_old);

   always_comb begin
      if (n_old == '0) begin
         status_in = STATUS_DEGENERATE;
      end else if (ndiff > ROOT_W'(tol_ff)) begin
         status_in = STATUS_MISMATCH;
      end else if (n_new == '0) begin
         status_in = STATUS_DEGENERATE;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff   <= status_in;
         n_old_ff    <= n_old;
         n_new_ff    <= n_new;
         chk_diff_ff <= dline_ff[SQRT_LAT-1];
      end
   end

   rt2p_div u_div_x1 (
      .clock (clock), .advance (advance), .d (chk_diff_ff.dxo), .den (n_old_ff), .q (ux1)
   );
   rt2p_div u_div_y1 (
      .clock (clock), .advance (advance), .d (chk_diff_ff.dyo), .den (n_old_ff), .q (uy1)
   );
   rt2p_div u_div_x2 (
      .clock (clock), .advance (advance), .d (chk_diff_ff.dxn), .den (n_new_ff), .q (ux2)
   );
   rt2p_div u_div_y2 (
      .clock (clock), .advance (advance), .d (chk_diff_ff.dyn), .den (n_new_ff), .q (uy2)
   );

   assign cr = round_q30(cv_ff);
   assign sr = round_q30(sv_ff);

   always_comb begin
      if (cr > ONE_Q30) begin
         c_in = UNIT_W'(ONE_Q30);
      end else if (cr < -ONE_Q30) begin
         c_in = UNIT_W'(-ONE_Q30);
      end else begin
         c_in = UNIT_W'(cr);
      end
      if (sr > ONE_Q30) begin
         s_in = UNIT_W'(ONE_Q30);
      end else if (sr < -ONE_Q30) begin
         s_in = UNIT_W'(-ONE_Q30);
      end else begin
         s_in = UNIT_W'(sr);
      end
   end

   assign ok_out = (sline_ff[STAT_DEPTH-1] == STATUS_OK);

   always_ff @(posedge clock) begin
      if (advance) begin
         pxx_ff <= ux1 * ux2;
         pyy_ff <= uy1 * uy2;
         pxy_ff <= ux1 * uy2;
         pyx_ff <= ux2 * uy1;
         cv_ff  <= WIDE_W'(pxx_ff) + WIDE_W'(pyy_ff);
         sv_ff  <= WIDE_W'(pxy_ff) - WIDE_W'(pyx_ff);
         c3_ff  <= c_in;
         s3_ff  <= s_in;
         m1_ff  <= cline_ff[S_P3-1].ox * c3_ff;
         m2_ff  <= cline_ff[S_P3-1].oy * s3_ff;
         m3_ff  <= cline_ff[S_P3-1].ox * s3_ff;
         m4_ff  <= cline_ff[S_P3-1].oy * c3_ff;
         c4_ff  <= c3_ff;
         s4_ff  <= s3_ff;
         ve_ff  <= WIDE_W'(m2_ff) - WIDE_W'(m1_ff);
         vf_ff  <= -WIDE_W'(m3_ff) - WIDE_W'(m4_ff);
         c5_ff  <= c4_ff;
         s5_ff  <= s4_ff;
         rsp_status_ff <= sline_ff[STAT_DEPTH-1];
         if (ok_out) begin
            rsp_entry_a_ff <= c5_ff;
            rsp_entry_b_ff <= -s5_ff;
            rsp_entry_c_ff <= s5_ff;
            rsp_entry_d_ff <= c5_ff;
            rsp_shift_x_ff <= SHIFT_W'(round_q30(ve_ff))
                              + SHIFT_W'(cline_ff[COORD_DEPTH-1].nx);
            rsp_shift_y_ff <= SHIFT_W'(round_q30(vf_ff))
                              + SHIFT_W'(cline_ff[COORD_DEPTH-1].ny);
         end else begin
            rsp_entry_a_ff <= '0;
            rsp_entry_b_ff <= '0;
            rsp_entry_c_ff <= '0;
            rsp_entry_d_ff <= '0;
            rsp_shift_x_ff <= '0;
            rsp_shift_y_ff <= '0;
         end
      end
   end

   assign rsp_valid   = valid_ff[PIPE_LAT-1];
   assign rsp_entry_a = rsp_entry_a_ff;
   assign rsp_entry_b = rsp_entry_b_ff;
   assign rsp_entry_c = rsp_entry_c_ff;
   assign rsp_entry_d = rsp_entry_d_ff;
   assign rsp_shift_x = rsp_shift_x_ff;
   assign rsp_shift_y = rsp_shift_y_ff;
   assign rsp_status  = rsp_status_ff;

   // A result that is not ok carries an all-zero matrix.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
      (rsp_entry_a == '0) && (rsp_entry_c == '0) && (rsp_shift_x == '0) && (rsp_shift_y == '0))
      else $error("non-ok result with nonzero matrix");

   // Cosine and sine stay within the unit range.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (RND_W'(rsp_entry_a) <= ONE_Q30) && (RND_W'(rsp_entry_a) >= -ONE_Q30)
                 && (RND_W'(rsp_entry_c) <= ONE_Q30) && (RND_W'(rsp_entry_c) >= -ONE_Q30))
      else $error("rotation entry out of unit range");

   // The rotation block is antisymmetric with equal diagonal.
   a_rot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_b == -rsp_entry_c) && (rsp_entry_a == rsp_entry_d))
      else $error("rotation entries inconsistent");

   // Only the three defined status codes leave the block.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_MISMATCH)
                 || (rsp_status == STATUS_DEGENERATE))
      else $error("undefined status code");

endmodule

@@ hdl/rt2p_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined segment length: floor(sqrt(dx*dx + dy*dy)), one root bit per stage.
// Depends on rt2p_pkg.
module rt2p_sqrt import rt2p_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [DIFF_W-1:0] dx,
   input  logic signed [DIFF_W-1:0] dy,
   output logic [ROOT_W-1:0]        root
);

   logic [DIFF_W-1:0] ax_in;
   logic [DIFF_W-1:0] ay_in;
   logic [MAG_W-1:0]  ax_ff;
   logic [MAG_W-1:0]  ay_ff;
   logic [SQ_W-1:0]   sx_ff;
   logic [SQ_W-1:0]   sy_ff;
   logic [RAD_W-1:0]  rad_ff;

   logic [REM_W-1:0]  rem_ff [SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff [SQRT_STEPS];
   logic [RAD_W-1:0]  sh_ff [SQRT_STEPS];

   assign ax_in = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign ay_in = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff  <= ax_in[MAG_W-1:0];
         ay_ff  <= ay_in[MAG_W-1:0];
         sx_ff  <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         sy_ff  <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         rad_ff <= RAD_W'(sx_ff) + RAD_W'(sy_ff);
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = sh_ff[i-1];
      end
      assign cur   = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (cur >= trial) begin
               rem_ff[i]  <= cur - trial;
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= cur;
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
            sh_ff[i] <= {rad_prev[RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

@@ hdl/rt2p_div.sv @@
`timescale 1ns / 1ps
// Pipelined rounded division round(d * 2^30 / den), one quotient bit per stage.
// Depends on rt2p_pkg.
module rt2p_div import rt2p_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [DIFF_W-1:0] d,
   input  logic [DEN_W-1:0]         den,
   output logic signed [UNIT_W-1:0] q
);

   logic [DIFF_W-1:0] mag_in;
   logic              sgn0_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den0_ff;

   logic [DEN_W-1:0]  rem_ff [DIV_STEPS];
   logic [QUO_W-1:0]  qw_ff [DIV_STEPS];
   logic [DEN_W-1:0]  den_ff [DIV_STEPS];
   logic              sgn_ff [DIV_STEPS];
   logic signed [UNIT_W-1:0] q_ff;

   assign mag_in = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);

   always_ff @(posedge clock) begin
      if (advance) begin
         sgn0_ff <= d[DIFF_W-1];
         num_ff  <= NUM_W'({mag_in[MAG_W-1:0], 30'b0}) + NUM_W'(den >> 1);
         den0_ff <= den;
      end
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [QUO_W-1:0] qw_prev;
      logic [DEN_W-1:0] den_prev;
      logic             sgn_prev;
      logic [DEN_W:0]   cur;
      if (i == 0) begin : g_first
         assign rem_prev = {1'b0, num_ff[NUM_W-1:QUO_W]};
         assign qw_prev  = num_ff[QUO_W-1:0];
         assign den_prev = den0_ff;
         assign sgn_prev = sgn0_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign qw_prev  = qw_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign sgn_prev = sgn_ff[i-1];
      end
      assign cur = {rem_prev, qw_prev[QUO_W-1]};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (cur >= {1'b0, den_prev}) begin
               rem_ff[i] <= DEN_W'(cur - {1'b0, den_prev});
               qw_ff[i]  <= {qw_prev[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= DEN_W'(cur);
               qw_ff[i]  <= {qw_prev[QUO_W-2:0], 1'b0};
            end
            den_ff[i] <= den_prev;
            sgn_ff[i] <= sgn_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= sgn_ff[DIV_STEPS-1] ? -UNIT_W'(qw_ff[DIV_STEPS-1])
                                     : UNIT_W'(qw_ff[DIV_STEPS-1]);
      end
   end

   assign q = q_ff;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rigid_transform_from_two_points: directed and random segment
// pairs, with expected results computed in-bench. Depends on rt2p_pkg and the block's RTL.
module tb;
   import rt2p_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] ox1, oy1, ox2, oy2, nx1, ny1, nx2, ny2;
   } segment_pair_type;

   typedef struct {
      logic signed [UNIT_W-1:0]  a, b, c, d;
      logic signed [SHIFT_W-1:0] ex, ey;
      logic [1:0]                status;
   } transform_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_old_first_x = '0, req_old_first_y = '0;
   logic signed [COORD_W-1:0] req_old_second_x = '0, req_old_second_y = '0;
   logic signed [COORD_W-1:0] req_new_first_x = '0, req_new_first_y = '0;
   logic signed [COORD_W-1:0] req_new_second_x = '0, req_new_second_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [UNIT_W-1:0] rsp_entry_a, rsp_entry_b, rsp_entry_c, rsp_entry_d;
   logic signed [SHIFT_W-1:0] rsp_shift_x, rsp_shift_y;
   logic [1:0] rsp_status;
   logic csr_write_enable = 1'b0;
   logic [TOL_W-1:0] csr_write_data = '0;

   logic [TOL_W-1:0] tolerance = TOL_RESET;
   transform_type pending_transforms[$];
   int unsigned error_count = 0;
   longint unsigned cycle_count = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned max_gap = 4;

   rigid_transform_from_two_points DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint unsigned segment_length(longint dx, longint dy);
      logic [65:0] rad;
      logic [69:0] rem, root, trial;
      longint unsigned ax, ay;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      rad = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      rem = '0;
      root = '0;
      for (int p = 64; p >= 0; p -= 2) begin
         rem = (rem << 2) | 70'(rad[p +: 2]);
         trial = (root << 2) | 70'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 70'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic longint divide_rounded(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic transform_type predict_transform(segment_pair_type s,
                                                       logic [TOL_W-1:0] tol);
      transform_type t;
      longint dxo, dyo, dxn, dyn, ux1, uy1, ux2, uy2, cs, sn, ex, ey;
      longint unsigned n1, n2, diff;
      longint unsigned q30;
      q30 = 64'd1 << 30;
      dxo = longint'(s.ox2) - longint'(s.ox1);
      dyo = longint'(s.oy2) - longint'(s.oy1);
      dxn = longint'(s.nx2) - longint'(s.nx1);
      dyn = longint'(s.ny2) - longint'(s.ny1);
      n1 = segment_length(dxo, dyo);
      n2 = segment_length(dxn, dyn);
      diff = (n1 > n2) ? n1 - n2 : n2 - n1;
      cs = 0; sn = 0; ex = 0; ey = 0;
      if (n1 == 0) t.status = STATUS_DEGENERATE;
      else if (diff > 64'(tol)) t.status = STATUS_MISMATCH;
      else if (n2 == 0) t.status = STATUS_DEGENERATE;
      else t.status = STATUS_OK;
      if (t.status == STATUS_OK) begin
         ux1 = divide_rounded(dxo * longint'(q30), n1);
         uy1 = divide_rounded(dyo * longint'(q30), n1);
         ux2 = divide_rounded(dxn * longint'(q30), n2);
         uy2 = divide_rounded(dyn * longint'(q30), n2);
         cs = clamp_unit(divide_rounded(ux1 * ux2 + uy1 * uy2, q30));
         sn = clamp_unit(divide_rounded(ux1 * uy2 - ux2 * uy1, q30));
         ex = divide_rounded(-longint'(s.ox1) * cs + longint'(s.oy1) * sn, q30)
              + longint'(s.nx1);
         ey = divide_rounded(-longint'(s.ox1) * sn - longint'(s.oy1) * cs, q30)
              + longint'(s.ny1);
      end
      t.a = UNIT_W'(cs);
      t.b = UNIT_W'(-sn);
      t.c = UNIT_W'(sn);
      t.d = UNIT_W'(cs);
      t.ex = SHIFT_W'(ex);
      t.ey = SHIFT_W'(ey);
      return t;
   endfunction

   // Called just after a rising edge; returns just after the edge of the transfer.
   task automatic send_pair(segment_pair_type s);
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_gap) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_old_first_x <= s.ox1;
      req_old_first_y <= s.oy1;
      req_old_second_x <= s.ox2;
      req_old_second_y <= s.oy2;
      req_new_first_x <= s.nx1;
      req_new_first_y <= s.ny1;
      req_new_second_x <= s.nx2;
      req_new_second_y <= s.ny2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_transforms = {pending_transforms, predict_transform(s, tolerance)};
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_transforms.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance = value;
   endtask

   function automatic segment_pair_type make_pair(longint ox1, longint oy1, longint ox2,
                                                   longint oy2, longint nx1, longint ny1,
                                                   longint nx2, longint ny2);
      segment_pair_type s;
      s.ox1 = COORD_W'(ox1); s.oy1 = COORD_W'(oy1);
      s.ox2 = COORD_W'(ox2); s.oy2 = COORD_W'(oy2);
      s.nx1 = COORD_W'(nx1); s.ny1 = COORD_W'(ny1);
      s.nx2 = COORD_W'(nx2); s.ny2 = COORD_W'(ny2);
      return s;
   endfunction

   function automatic longint signed_range(int unsigned bits);
      return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
   endfunction

   // Mostly an exact rotation or mirror of the old segment, sometimes jittered,
   // and some pairs of fully random coordinates.
   function automatic segment_pair_type random_pair();
      segment_pair_type s;
      longint ox, oy, dx, dy, nx, ny, mx, my, tmp;
      int unsigned k;
      if ($urandom_range(0, 9) < 2) begin
         s = make_pair(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom), int'($urandom), int'($urandom), int'($urandom));
         return s;
      end
      k = $urandom_range(2, 22);
      ox = signed_range(24); oy = signed_range(24);
      dx = signed_range(k); dy = signed_range(k);
      nx = signed_range(28); ny = signed_range(28);
      mx = dx; my = dy;
      if ($urandom_range(0, 1)) begin tmp = mx; mx = -my; my = tmp; end
      if ($urandom_range(0, 1)) mx = -mx;
      if ($urandom_range(0, 1)) my = -my;
      if ($urandom_range(0, 1)) begin tmp = mx; mx = my; my = tmp; end
      if ($urandom_range(0, 4) == 0) begin
         mx = mx + $urandom_range(0, 2) - 1;
         my = my + $urandom_range(0, 2) - 1;
      end
      return make_pair(ox, oy, ox + dx, oy + dy, nx, ny, nx + mx, ny + my);
   endfunction

   task automatic test_degenerate_segments;
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(5, 7, 5, 7, 1, 1, 9, 9));
      send_pair(make_pair(0, 0, 1, 0, 3, 3, 3, 3));
      send_pair(make_pair(0, 0, 10, 0, 3, 3, 3, 3));
      send_pair(make_pair(100, 100, 100, 100, 0, 0, 0, 0));
   endtask

   task automatic test_length_tolerance;
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 20));
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 11));
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 12));
      send_pair(make_pair(0, 0, 1, 1, 0, 0, 2, 0));
      send_pair(make_pair(0, 0, 3, 4, 7, 7, 2, 7));
   endtask

   task automatic test_coordinate_extremes;
      longint mn, mx;
      mn = -(longint'(1) << 31);
      mx = (longint'(1) << 31) - 1;
      send_pair(make_pair(mn, mn, mx, mx, mn, mn, mx, mx));
      send_pair(make_pair(mn, mn, mx, mx, mx, mx, mn, mn));
      send_pair(make_pair(mx, mn, mn, mx, mn, mx, mx, mn));
      send_pair(make_pair(mx, mx, mx, mx - 65536, mn, mn, mn + 65536, mn));
      send_pair(make_pair(mn, mx, mn + 1, mx, mx, mn, mx, mn - 1));
      send_pair(make_pair(-1, -1, 0, 0, mx, mn, mx - 1, mn + 1));
      send_pair(make_pair(65536, 0, 65536, 65536, 0, 0, 65536, 0));
      send_pair(make_pair(mx, mx, 0, 0, 0, 0, mx, mx));
   endtask

   task automatic test_tolerance_settings;
      write_tolerance(16'd0);
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 11));
      send_pair(make_pair(0, 0, 1, 1, 0, 0, 2, 0));
      for (int i = 0; i < 150; i++) send_pair(random_pair());
      drain();
      write_tolerance(16'hFFFF);
      send_pair(make_pair(0, 0, 65535, 0, 4, 4, 4, 5));
      send_pair(make_pair(0, 0, 65536, 0, 4, 4, 4, 5));
      for (int i = 0; i < 150; i++) send_pair(random_pair());
      drain();
   endtask

   task automatic test_random_transforms;
      for (int phase = 0; phase < 3; phase++) begin
         write_tolerance(16'($urandom_range(0, 8)));
         max_gap = (phase == 1) ? 12 : 3;
         for (int i = 0; i < 170; i++) send_pair(random_pair());
         drain();
      end
   endtask

   task automatic test_backpressure;
      write_tolerance(16'd2);
      max_gap = 1;
      hold_off_cycles = 300;
      for (int i = 0; i < 140; i++) send_pair(random_pair());
      drain();
   endtask

   always @(posedge clock) begin
      transform_type want;
      int unsigned hold_left;
      int unsigned stall_mode;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_transforms.size() == 0) begin
            error_count = error_count + 1;
            if (error_count <= 10)
               $display("Unexpected result transfer at cycle %0d", cycle_count);
         end else begin
            want = pending_transforms.pop_front();
            if (rsp_entry_a !== want.a || rsp_entry_b !== want.b || rsp_entry_c !== want.c
                || rsp_entry_d !== want.d || rsp_shift_x !== want.ex
                || rsp_shift_y !== want.ey || rsp_status !== want.status) begin
               error_count = error_count + 1;
               if (error_count <= 10) begin
                  $display("Mismatch: expected a=%0d b=%0d c=%0d d=%0d e=%0d f=%0d st=%0d",
                           want.a, want.b, want.c, want.d, want.ex, want.ey, want.status);
                  $display("          got      a=%0d b=%0d c=%0d d=%0d e=%0d f=%0d st=%0d",
                           rsp_entry_a, rsp_entry_b, rsp_entry_c, rsp_entry_d,
                           rsp_shift_x, rsp_shift_y, rsp_status);
               end
            end
         end
      end
      if (hold_off_cycles != 0) begin
         hold_left = hold_off_cycles;
         hold_off_cycles = 0;
      end
      stall_mode = 32'((cycle_count / 256) % 3);
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degenerate_segments();
      test_length_tolerance();
      test_coordinate_extremes();
      drain();
      test_tolerance_settings();
      test_random_transforms();
      test_backpressure();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
